[rtl/drr_pkg.sv]
`timescale 1ns / 1ps

package drr_pkg;

    // Field widths of one input item and one result item
    localparam int ADDR_W   = 32;
    localparam int LEN_W    = 16;
    localparam int FILL_W   = 32;
    localparam int SLOT_W   = 6;
    localparam int OP_W     = 2;
    localparam int KIND_W   = 3;
    localparam int TOTAL_W  = 17;

    // Pass limits and register reset
    localparam int          MAX_RESULTS  = 64;
    localparam int          CNT_W        = 7;
    localparam logic [15:0] BUDGET_RESET = 16'd40960;

    // Transfer operation codes
    localparam logic [OP_W-1:0] OP_COPY32 = 2'd0;
    localparam logic [OP_W-1:0] OP_FILL32 = 2'd1;
    localparam logic [OP_W-1:0] OP_COPY16 = 2'd2;
    localparam logic [OP_W-1:0] OP_FILL16 = 2'd3;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR    = 3'd0,
        KIND_COPY     = 3'd1,
        KIND_FILL     = 3'd2,
        KIND_PROCESS  = 3'd3,
        KIND_WAIT_ONE = 3'd4,
        KIND_WAIT_ALL = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SEARCH,
        ST_PCHECK,
        ST_PREAD,
        ST_FINISH,
        ST_EMIT
    } state_t;

    // One input item
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] src_addr;
        logic [ADDR_W-1:0] dest_addr;
        logic [LEN_W-1:0]  byte_count;
        logic              wide;
        logic [FILL_W-1:0] fill_word;
        logic [SLOT_W-1:0] slot_index;
    } req_t;

    // One stored descriptor; aux is the source of a copy or the value of a fill
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] dest;
        logic [FILL_W-1:0] aux;
    } desc_t;

    localparam int DESC_W = $bits(desc_t);

    // One result item, without the last marker
    typedef struct packed {
        logic              accepted;
        logic [SLOT_W-1:0] slot;
        logic              busy_res;
        logic              xfer_valid;
        logic [OP_W-1:0]   xfer_op;
        logic [ADDR_W-1:0] xfer_src;
        logic [ADDR_W-1:0] xfer_dest;
        logic [LEN_W-1:0]  xfer_bytes;
        logic [FILL_W-1:0] xfer_fill;
    } result_t;

    // Busy map commands, one per cycle at most
    typedef struct packed {
        logic set;
        logic clr;
        logic wipe;
    } map_cmd_t;

    function automatic result_t desc_to_result(desc_t d);
        result_t r;
        r            = '0;
        r.xfer_valid = 1'b1;
        r.xfer_op    = d.op;
        r.xfer_src   = d.op[0] ? '0 : d.aux;
        r.xfer_dest  = d.dest;
        r.xfer_bytes = d.len;
        r.xfer_fill  = d.op[0] ? d.aux : '0;
        return r;
    endfunction

endpackage

[rtl/drr_ram.sv]
`timescale 1ns / 1ps

module drr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port; read data holds while rd_en is low
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/drr_slot_map.sv]
`timescale 1ns / 1ps

module drr_slot_map #(
    parameter int RING_DEPTH = 64,
    parameter int IDX_W      = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  drr_pkg::map_cmd_t cmd,
    input  logic [IDX_W-1:0] idx,
    input  logic [IDX_W-1:0] query_idx,
    output logic             idx_busy,
    output logic             query_busy,
    output logic             any_busy,
    output logic             full
);
    import drr_pkg::*;

    localparam int CNT_MAP_W = $clog2(RING_DEPTH + 1);

    logic [RING_DEPTH-1:0] busy_reg, busy_next;
    logic [CNT_MAP_W-1:0]  cnt_reg, cnt_next;

    // One busy bit per slot (nonzero length) and a running count of busy slots
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (cmd.wipe) begin
            busy_next = '0;
            cnt_next  = '0;
        end else if (cmd.set) begin
            busy_next[idx] = 1'b1;
            cnt_next       = cnt_reg + CNT_MAP_W'(1);
        end else if (cmd.clr) begin
            busy_next[idx] = 1'b0;
            cnt_next       = cnt_reg - CNT_MAP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign idx_busy   = busy_reg[idx];
    assign query_busy = busy_reg[query_idx];
    assign any_busy   = (cnt_reg != '0);
    assign full       = (cnt_reg == CNT_MAP_W'(RING_DEPTH));

endmodule

[rtl/drr_ctrl.sv]
`timescale 1ns / 1ps

module drr_ctrl #(
    parameter int RING_DEPTH = 64,
    parameter int IDX_W      = 6
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // input items
    input  logic                      in_valid,
    output logic                      in_ready,
    input  drr_pkg::req_t             in_req,
    // budget register
    input  logic                      cfg_we,
    input  logic [15:0]               cfg_wdata,
    // result items
    output logic                      out_valid,
    input  logic                      out_ready,
    output drr_pkg::result_t          out_res,
    output logic                      out_last,
    // descriptor memory
    output logic                      ram_we,
    output logic [IDX_W-1:0]          ram_waddr,
    output drr_pkg::desc_t            ram_wdata,
    output logic                      ram_re,
    output logic [IDX_W-1:0]          ram_raddr,
    input  drr_pkg::desc_t            ram_rdata,
    // busy map
    output drr_pkg::map_cmd_t         map_cmd,
    output logic [IDX_W-1:0]          map_idx,
    output logic [IDX_W-1:0]          map_query_idx,
    input  logic                      map_idx_busy,
    input  logic                      map_query_busy,
    input  logic                      map_any_busy,
    input  logic                      map_full
);
    import drr_pkg::*;

    localparam int                EXT_W = IDX_W + SLOT_W;
    localparam logic [IDX_W-1:0]  LAST_POS = IDX_W'(RING_DEPTH - 1);

    state_t               state_reg, state_next;
    req_t                 req_reg, req_next;
    logic [IDX_W-1:0]     cursor_reg, cursor_next;
    logic [IDX_W-1:0]     pos_reg, pos_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 pend_valid_reg, pend_valid_next;
    result_t              pend_reg, pend_next;
    result_t              res_reg, res_next;
    logic [15:0]          budget_reg;
    logic                 out_valid_reg;
    result_t              out_res_reg;
    logic                 out_last_reg;

    logic                 out_free;
    logic                 out_load;
    result_t              out_res_next;
    logic                 out_last_next;
    logic [IDX_W-1:0]     pos_inc;
    logic [EXT_W-1:0]     pos_ext;
    logic [EXT_W-1:0]     qidx_ext;
    logic [TOTAL_W-1:0]   sum;
    desc_t                new_desc;

    assign out_free = !out_valid_reg || out_ready;
    assign pos_inc  = (pos_reg == LAST_POS) ? '0 : pos_reg + IDX_W'(1);
    assign pos_ext  = EXT_W'(pos_reg);
    assign qidx_ext = EXT_W'(req_reg.slot_index);
    assign sum      = total_reg + TOTAL_W'(ram_rdata.len);

    // Descriptor built from the latched request
    always_comb begin
        new_desc.len  = req_reg.byte_count;
        new_desc.dest = req_reg.dest_addr;
        if (kind_t'(req_reg.kind) == KIND_COPY) begin
            new_desc.op  = req_reg.wide ? OP_COPY32 : OP_COPY16;
            new_desc.aux = req_reg.src_addr;
        end else begin
            new_desc.op  = req_reg.wide ? OP_FILL32 : OP_FILL16;
            new_desc.aux = req_reg.fill_word;
        end
    end

    assign map_idx       = pos_reg;
    assign map_query_idx = qidx_ext[IDX_W-1:0];
    assign ram_waddr     = pos_reg;
    assign ram_raddr     = pos_reg;
    assign ram_wdata     = new_desc;

    // Sequencer: next state, memory and map commands, result loading
    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        cursor_next     = cursor_reg;
        pos_next        = pos_reg;
        total_next      = total_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        res_next        = res_reg;
        in_ready        = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        map_cmd         = '0;
        out_load        = 1'b0;
        out_res_next    = '0;
        out_last_next   = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    req_next   = in_req;
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE: begin
                res_next   = '0;
                state_next = ST_EMIT;
                unique case (kind_t'(req_reg.kind))
                    KIND_CLEAR: begin
                        map_cmd.wipe = 1'b1;
                        cursor_next  = '0;
                    end
                    KIND_COPY, KIND_FILL: begin
                        // full ring: not accepted, nothing changes
                        if (!map_full) begin
                            pos_next   = cursor_reg;
                            state_next = ST_SEARCH;
                        end
                    end
                    KIND_PROCESS: begin
                        pos_next        = cursor_reg;
                        total_next      = '0;
                        count_next      = '0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_PCHECK;
                    end
                    KIND_WAIT_ONE: begin
                        res_next.busy_res = (qidx_ext < EXT_W'(RING_DEPTH)) && map_query_busy;
                    end
                    KIND_WAIT_ALL: begin
                        res_next.busy_res = map_any_busy;
                    end
                    default: begin
                        // unused kinds give one empty result
                    end
                endcase
            end

            // Walk one slot a cycle from the cursor to the first empty one
            ST_SEARCH: begin
                if (!map_idx_busy) begin
                    ram_we            = 1'b1;
                    map_cmd.set       = (req_reg.byte_count != '0);
                    res_next          = '0;
                    res_next.accepted = 1'b1;
                    res_next.slot     = pos_ext[SLOT_W-1:0];
                    state_next        = ST_EMIT;
                end else begin
                    pos_next = pos_inc;
                end
            end

            // Process pass: look at the busy bit, then read the descriptor
            ST_PCHECK: begin
                if (count_reg == CNT_W'(MAX_RESULTS) || !map_idx_busy) begin
                    state_next = ST_FINISH;
                end else begin
                    ram_re     = 1'b1;
                    state_next = ST_PREAD;
                end
            end

            ST_PREAD: begin
                if (sum > TOTAL_W'(budget_reg)) begin
                    // over budget: descriptor stays queued
                    state_next = ST_FINISH;
                end else if (!pend_valid_reg || out_free) begin
                    // the held transfer is known not to be the last one
                    if (pend_valid_reg) begin
                        out_load     = 1'b1;
                        out_res_next = pend_reg;
                    end
                    pend_valid_next = 1'b1;
                    pend_next       = desc_to_result(ram_rdata);
                    map_cmd.clr     = 1'b1;
                    total_next      = sum;
                    count_next      = count_reg + CNT_W'(1);
                    pos_next        = pos_inc;
                    state_next      = ST_PCHECK;
                end
            end

            ST_FINISH: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_res_next  = pend_valid_reg ? pend_reg : '0;
                    out_last_next = 1'b1;
                    cursor_next   = pos_reg;
                    state_next    = ST_IDLE;
                end
            end

            ST_EMIT: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_res_next  = res_reg;
                    out_last_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cursor_reg     <= '0;
            pend_valid_reg <= 1'b0;
            budget_reg     <= BUDGET_RESET;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cursor_reg     <= cursor_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_we) begin
                budget_reg <= cfg_wdata;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        req_reg   <= req_next;
        pos_reg   <= pos_next;
        total_reg <= total_next;
        count_reg <= count_next;
        pend_reg  <= pend_next;
        res_reg   <= res_next;
        if (out_load) begin
            out_res_reg  <= out_res_next;
            out_last_reg <= out_last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_last  = out_last_reg;

endmodule

[rtl/dma_request_ring_manager.sv]
`timescale 1ns / 1ps
// Clear, wait and unused kinds go through the decode and emit states to reach m_tvalid; a request
// also walks the slots from the cursor to the first empty one, and a process pass alternates the
// check and read states per transfer issued, reads the refused descriptor when the budget stops
// the pass, and ends in the finish state. One item at a time: no new item is taken until the last
// result of the current one is loaded into the output register.
// Reset (aresetn low, synchronous): busy map, cursor and output cleared, budget 40960;
// the descriptor memory is not swept, so items are taken from the first cycle after reset.

module dma_request_ring_manager #(
    parameter int RING_DEPTH = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] src_addr, [63:32] dest_addr, [79:64] byte_count, [80] wide,
    // [112:81] fill_word, [118:113] slot_index, [119] zero
    input  logic [119:0] s_tdata,
    // [2:0] kind
    input  logic [2:0]   s_tuser,
    // budget register
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata,
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    // [0] accepted, [6:1] slot, [7] busy_res, [8] xfer_valid, [10:9] xfer_op,
    // [42:11] xfer_src, [74:43] xfer_dest, [90:75] xfer_bytes, [122:91] xfer_fill,
    // [127:123] zero
    output logic [127:0] m_tdata,
    output logic         m_tlast
);
    import drr_pkg::*;

    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    req_t              in_req;
    result_t           out_res;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    desc_t             ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [DESC_W-1:0] ram_rdata_raw;
    map_cmd_t          map_cmd;
    logic [IDX_W-1:0]  map_idx;
    logic [IDX_W-1:0]  map_query_idx;
    logic              map_idx_busy;
    logic              map_query_busy;
    logic              map_any_busy;
    logic              map_full;

    // Unpack the input item
    assign in_req.kind       = s_tuser[2:0];
    assign in_req.src_addr   = s_tdata[31:0];
    assign in_req.dest_addr  = s_tdata[63:32];
    assign in_req.byte_count = s_tdata[79:64];
    assign in_req.wide       = s_tdata[80];
    assign in_req.fill_word  = s_tdata[112:81];
    assign in_req.slot_index = s_tdata[118:113];

    drr_ram #(
        .WIDTH (DESC_W),
        .DEPTH (RING_DEPTH)
    ) u_desc_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata_raw)
    );

    drr_slot_map #(
        .RING_DEPTH (RING_DEPTH),
        .IDX_W      (IDX_W)
    ) u_slot_map (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (map_cmd),
        .idx        (map_idx),
        .query_idx  (map_query_idx),
        .idx_busy   (map_idx_busy),
        .query_busy (map_query_busy),
        .any_busy   (map_any_busy),
        .full       (map_full)
    );

    drr_ctrl #(
        .RING_DEPTH (RING_DEPTH),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_req         (in_req),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_res        (out_res),
        .out_last       (m_tlast),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_re         (ram_re),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (desc_t'(ram_rdata_raw)),
        .map_cmd        (map_cmd),
        .map_idx        (map_idx),
        .map_query_idx  (map_query_idx),
        .map_idx_busy   (map_idx_busy),
        .map_query_busy (map_query_busy),
        .map_any_busy   (map_any_busy),
        .map_full       (map_full)
    );

    // Pack the result item
    assign m_tdata[0]       = out_res.accepted;
    assign m_tdata[6:1]     = out_res.slot;
    assign m_tdata[7]       = out_res.busy_res;
    assign m_tdata[8]       = out_res.xfer_valid;
    assign m_tdata[10:9]    = out_res.xfer_op;
    assign m_tdata[42:11]   = out_res.xfer_src;
    assign m_tdata[74:43]   = out_res.xfer_dest;
    assign m_tdata[90:75]   = out_res.xfer_bytes;
    assign m_tdata[122:91]  = out_res.xfer_fill;
    assign m_tdata[127:123] = '0;

endmodule

[rtl/drr_checker.sv]
`timescale 1ns / 1ps

module drr_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic         m_tlast
);

    // A stalled result holds still
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // One item at a time: input closes right after an item is taken
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input open right after an item was taken");

    // Reset empties the output register
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A request answer is a single result and carries no transfer
    a_accept_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> !m_tdata[8] && m_tlast)
        else $error("accepted request with transfer or without last");

    // An issued transfer never has zero length
    a_xfer_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> m_tdata[90:75] != 16'd0)
        else $error("issued transfer of zero bytes");

endmodule

bind dma_request_ring_manager drr_checker u_drr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

[verif/dma_request_ring_manager_test.sv]
`timescale 1ns / 1ps

module dma_request_ring_manager_test;
    import drr_pkg::*;

    localparam int RING_SLOTS    = 64;
    localparam int QUIET_LIMIT   = 2000;              // cycles with no handshake at all
    localparam int SETTLE_CYCLES = 16;
    localparam int END_CYCLES    = 2 * MAX_RESULTS + 8;
    localparam int PRINT_CAP     = 40;
    localparam int ITEM_W        = 120;

    // Kind codes the block leaves unused
    localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;

    typedef struct {
        result_t body;
        logic    last;
    } ring_result_t;

    // Descriptor ring predictor and result checker
    class ring_scoreboard;
        logic [LEN_W-1:0]  slot_len  [RING_SLOTS];
        logic [ADDR_W-1:0] slot_src  [RING_SLOTS];
        logic [ADDR_W-1:0] slot_dest [RING_SLOTS];
        logic [OP_W-1:0]   slot_op   [RING_SLOTS];
        logic [FILL_W-1:0] slot_fill [RING_SLOTS];
        logic [SLOT_W-1:0] cursor;
        logic [15:0]       budget;
        ring_result_t      due_results[$];
        int unsigned       mismatch_count;

        function new();
            clear_ring();
            budget         = BUDGET_RESET;
            mismatch_count = 0;
        endfunction

        function void clear_ring();
            foreach (slot_len[i]) begin
                slot_len[i]  = '0;
                slot_src[i]  = '0;
                slot_dest[i] = '0;
                slot_op[i]   = '0;
                slot_fill[i] = '0;
            end
            cursor = '0;
        endfunction

        // Work out the results of one accepted item and queue them
        function void note_accepted_item(logic [KIND_W-1:0] kind, logic [ITEM_W-1:0] data);
            ring_result_t       batch[$];
            ring_result_t       r;
            logic [ADDR_W-1:0]  src;
            logic [ADDR_W-1:0]  dest;
            logic [LEN_W-1:0]   len;
            logic               wide;
            logic [FILL_W-1:0]  fill;
            logic [SLOT_W-1:0]  idx;
            logic [SLOT_W-1:0]  pos;
            logic [OP_W-1:0]    op;
            logic [TOTAL_W-1:0] total;
            logic               found;
            logic               halt;
            src    = data[31:0];
            dest   = data[63:32];
            len    = data[79:64];
            wide   = data[80];
            fill   = data[112:81];
            idx    = data[118:113];
            r.body = '0;
            r.last = 1'b0;
            case (kind)
                KIND_COPY, KIND_FILL: begin
                    // first empty slot from the cursor, wrapping once
                    found = 1'b0;
                    pos   = cursor;
                    for (int n = 0; n < RING_SLOTS && !found; n++) begin
                        if (slot_len[pos] == '0) begin
                            found = 1'b1;
                        end else begin
                            pos = pos + 1'b1;
                        end
                    end
                    if (found) begin
                        slot_len[pos]  = len;
                        slot_dest[pos] = dest;
                        if (kind == KIND_COPY) begin
                            slot_src[pos] = src;
                            slot_op[pos]  = wide ? OP_COPY32 : OP_COPY16;
                        end else begin
                            slot_fill[pos] = fill;
                            slot_op[pos]   = wide ? OP_FILL32 : OP_FILL16;
                        end
                        r.body.accepted = 1'b1;
                        r.body.slot     = pos;
                    end
                    batch.push_back(r);
                end
                KIND_CLEAR: begin
                    clear_ring();
                    batch.push_back(r);
                end
                KIND_WAIT_ONE: begin
                    r.body.busy_res = (slot_len[idx] != '0);
                    batch.push_back(r);
                end
                KIND_WAIT_ALL: begin
                    foreach (slot_len[i]) begin
                        if (slot_len[i] != '0) r.body.busy_res = 1'b1;
                    end
                    batch.push_back(r);
                end
                KIND_PROCESS: begin
                    // issue in ring order until an empty slot, the budget or MAX_RESULTS transfers is hit
                    total = '0;
                    pos   = cursor;
                    halt  = 1'b0;
                    while (!halt && batch.size() < MAX_RESULTS && slot_len[pos] != '0) begin
                        total = total + slot_len[pos];
                        if (total > budget) begin
                            halt = 1'b1;
                        end else begin
                            op                = slot_op[pos];
                            r.body            = '0;
                            r.body.xfer_valid = 1'b1;
                            r.body.xfer_op    = op;
                            r.body.xfer_dest  = slot_dest[pos];
                            r.body.xfer_bytes = slot_len[pos];
                            if (op == OP_FILL32 || op == OP_FILL16) begin
                                r.body.xfer_fill = slot_fill[pos];
                            end else begin
                                r.body.xfer_src = slot_src[pos];
                            end
                            batch.push_back(r);
                            slot_len[pos] = '0;
                            pos           = pos + 1'b1;
                        end
                    end
                    cursor = pos;
                    if (batch.size() == 0) begin
                        r.body = '0;
                        batch.push_back(r);
                    end
                end
                default: begin
                    batch.push_back(r);
                end
            endcase
            batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i]) due_results.push_back(batch[i]);
        endfunction

        task report_mismatch(input string msg);
            if (mismatch_count < PRINT_CAP) $display("mismatch: %s", msg);
            mismatch_count++;
        endtask

        task compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("%s got %h want %h", name, got, want));
            end
        endtask

        // Compare one result item with the oldest expectation
        task check_result(input logic [127:0] data, input logic last);
            ring_result_t want;
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("result %h last %b with none expected", data, last));
                return;
            end
            want = due_results.pop_front();
            compare_field("accepted",   data[0],      want.body.accepted);
            compare_field("slot",       data[6:1],    want.body.slot);
            compare_field("busy_res",   data[7],      want.body.busy_res);
            compare_field("xfer_valid", data[8],      want.body.xfer_valid);
            compare_field("xfer_op",    data[10:9],   want.body.xfer_op);
            compare_field("xfer_src",   data[42:11],  want.body.xfer_src);
            compare_field("xfer_dest",  data[74:43],  want.body.xfer_dest);
            compare_field("xfer_bytes", data[90:75],  want.body.xfer_bytes);
            compare_field("xfer_fill",  data[122:91], want.body.xfer_fill);
            compare_field("last",       last,         want.last);
        endtask
    endclass

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [ITEM_W-1:0] s_tdata   = '0;
    logic [KIND_W-1:0] s_tuser   = '0;
    logic              cfg_we    = 1'b0;
    logic [15:0]       cfg_wdata = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [127:0]      m_tdata;
    logic              m_tlast;

    ring_scoreboard ledger = new();

    int unsigned idle_pct      = 0;
    int unsigned stall_pct     = 0;
    int unsigned gap_left      = 0;
    int unsigned counted_items = 0;
    int unsigned quiet_cycles  = 0;

    dma_request_ring_manager #(
        .RING_DEPTH(RING_SLOTS)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #6 aclk = ~aclk;

    // Result monitor and random receiver stall
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) ledger.check_result(m_tdata, m_tlast);
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [ITEM_W-1:0] pack_item(input logic [ADDR_W-1:0] src,
                                                    input logic [ADDR_W-1:0] dest,
                                                    input logic [LEN_W-1:0]  len,
                                                    input logic              wide,
                                                    input logic [FILL_W-1:0] fill,
                                                    input logic [SLOT_W-1:0] idx);
        return {1'b0, idx, fill, wide, len, dest, src};
    endfunction

    // Random fields; lengths lean small so a pass issues several transfers
    function automatic logic [ITEM_W-1:0] random_fields();
        int unsigned      pick;
        logic [LEN_W-1:0] len;
        pick = $urandom_range(99);
        if (pick < 10) begin
            len = '0;
        end else if (pick < 45) begin
            len = LEN_W'($urandom_range(1, 1500));
        end else if (pick < 65) begin
            len = LEN_W'($urandom_range(1, 16384));
        end else if (pick < 75) begin
            len = LEN_W'($urandom_range(65000, 65535));
        end else begin
            len = LEN_W'($urandom());
        end
        return pack_item($urandom(), $urandom(), len, 1'($urandom_range(1)), $urandom(),
                         SLOT_W'($urandom_range(RING_SLOTS - 1)));
    endfunction

    // Offer one item; tvalid stays up when the next one follows at once
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [ITEM_W-1:0] data);
        while (gap_left > 0) begin
            @(posedge aclk);
            gap_left--;
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        ledger.note_accepted_item(kind, data);
        if (kind != KIND_SPARE6 && kind != KIND_SPARE7) counted_items++;
        while (gap_left < 24 && $urandom_range(99) < idle_pct) gap_left++;
        if (gap_left > 0) s_tvalid <= 1'b0;
    endtask

    // Drop tvalid, wait for every expected result, then let the block go idle
    task automatic settle(input int unsigned cycles);
        if (gap_left == 0) s_tvalid <= 1'b0;
        gap_left = 0;
        while (ledger.due_results.size() != 0) @(posedge aclk);
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic write_budget(input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        ledger.budget = value;
        cfg_we <= 1'b0;
    endtask

    // Mostly request bursts followed by service passes and queries
    task automatic run_random(input int unsigned quota);
        int unsigned target;
        int unsigned pick;
        int unsigned burst;
        target = counted_items + quota;
        while (counted_items < target) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                burst = ($urandom_range(9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 16);
                repeat (burst) send_item($urandom_range(1) ? KIND_COPY : KIND_FILL, random_fields());
                repeat ($urandom_range(1, 2)) send_item(KIND_PROCESS, random_fields());
                send_item($urandom_range(1) ? KIND_WAIT_ONE : KIND_WAIT_ALL, random_fields());
            end else if (pick < 64) begin
                send_item(KIND_CLEAR, random_fields());
            end else if (pick < 66) begin
                send_item($urandom_range(1) ? KIND_SPARE6 : KIND_SPARE7, random_fields());
            end else begin
                send_item(KIND_W'($urandom_range(KIND_WAIT_ALL)), random_fields());
            end
        end
    endtask

    initial begin
        logic [15:0] budget_plan [8];
        budget_plan[0] = 16'hFFFF;
        budget_plan[1] = BUDGET_RESET;
        budget_plan[2] = 16'd0;
        budget_plan[3] = 16'($urandom());
        budget_plan[4] = 16'd1;
        budget_plan[5] = 16'hFFFF;
        budget_plan[6] = 16'($urandom());
        budget_plan[7] = 16'd4096;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty ring, every operation but clear, over-budget head, unused kinds
        send_item(KIND_WAIT_ALL, '0);
        send_item(KIND_PROCESS, '0);
        send_item(KIND_COPY, pack_item('1, '0, '1, 1'b1, '0, '0));
        send_item(KIND_FILL, pack_item('0, '1, 16'd1, 1'b0, '1, '1));
        send_item(KIND_COPY, pack_item(32'h0000_1000, 32'h0000_2000, '0, 1'b0, '0, '0));
        send_item(KIND_FILL, pack_item('0, 32'h8000_0000, 16'h8000, 1'b1, 32'hA5A5_5A5A, '0));
        send_item(KIND_WAIT_ONE, pack_item('0, '0, '0, 1'b0, '0, 6'd0));
        send_item(KIND_WAIT_ONE, pack_item('0, '0, '0, 1'b0, '0, '1));
        send_item(KIND_PROCESS, '0);
        send_item(KIND_SPARE6, pack_item('1, '1, '1, 1'b1, '1, '1));
        send_item(KIND_SPARE7, '0);
        settle(SETTLE_CYCLES);

        // Full budget: the longest copy goes alone, the rest on the next pass
        write_budget(16'hFFFF);
        send_item(KIND_PROCESS, '0);
        send_item(KIND_PROCESS, '0);
        send_item(KIND_WAIT_ALL, '0);
        send_item(KIND_COPY, pack_item(32'h1234_5678, 32'h9ABC_DEF0, 16'd64, 1'b0, '0, '0));
        send_item(KIND_CLEAR, '0);
        send_item(KIND_WAIT_ALL, '0);
        send_item(KIND_WAIT_ONE, pack_item('0, '0, '0, 1'b0, '0, 6'd3));
        settle(SETTLE_CYCLES);

        // Random phases: pairs share an idling mode, each with its own budget
        for (int p = 0; p < 8; p++) begin
            case (p / 2)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 63; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 63; end
                default: begin idle_pct = 36; stall_pct = 36; end
            endcase
            write_budget(budget_plan[p]);
            run_random(50);
            settle(p == 7 ? END_CYCLES : SETTLE_CYCLES);
        end

        if (ledger.mismatch_count == 0 && ledger.due_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[dma_request_ring_manager.f]
rtl/drr_pkg.sv
rtl/drr_ram.sv
rtl/drr_slot_map.sv
rtl/drr_ctrl.sv
rtl/dma_request_ring_manager.sv
rtl/drr_checker.sv
verif/dma_request_ring_manager_test.sv
